/* hw/rtl/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared types, constants and the float automaton transition table for the
// numeric token classifier.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int VALUE_WIDTH = 32;

    typedef logic [VALUE_WIDTH-1:0] t_value;

    // result kinds
    localparam logic [1:0] KIND_INT    = 2'd0;
    localparam logic [1:0] KIND_FLOAT  = 2'd1;
    localparam logic [1:0] KIND_SYMBOL = 2'd2;

    // character classes seen by the float automaton
    localparam logic [2:0] CLS_SIGN  = 3'd0;
    localparam logic [2:0] CLS_DIGIT = 3'd1;
    localparam logic [2:0] CLS_EXP   = 3'd2;
    localparam logic [2:0] CLS_DOT   = 3'd3;
    localparam logic [2:0] CLS_OTHER = 3'd4;

    // float automaton states
    localparam logic [3:0] FS_START  = 4'd0;
    localparam logic [3:0] FS_DEAD   = 4'd15;
    localparam int         FS_COUNT  = 10;

    localparam logic [3:0] NEXT_SIGN [FS_COUNT] =
        '{4'd1, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd8, 4'd15, 4'd15};
    localparam logic [3:0] NEXT_DIGIT [FS_COUNT] =
        '{4'd2, 4'd2, 4'd2, 4'd4, 4'd4, 4'd6, 4'd6, 4'd9, 4'd9, 4'd9};
    localparam logic [3:0] NEXT_EXP [FS_COUNT] =
        '{4'd15, 4'd15, 4'd7, 4'd7, 4'd7, 4'd15, 4'd7, 4'd15, 4'd15, 4'd15};
    localparam logic [3:0] NEXT_DOT [FS_COUNT] =
        '{4'd5, 4'd5, 4'd3, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15};

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]          kind;
        logic signed [31:0]  int_value;
    } t_out_beat;

    function automatic logic [3:0] float_next(input logic [3:0] st, input logic [2:0] cls);
        logic [3:0] nxt;
        nxt = FS_DEAD;
        if (st < 4'(FS_COUNT)) begin
            case (cls)
                CLS_SIGN:  nxt = NEXT_SIGN[st];
                CLS_DIGIT: nxt = NEXT_DIGIT[st];
                CLS_EXP:   nxt = NEXT_EXP[st];
                CLS_DOT:   nxt = NEXT_DOT[st];
                default:   nxt = FS_DEAD;
            endcase
        end
        return nxt;
    endfunction

endpackage

/* hw/rtl/ntc_lexer.sv */
// ----------------------------------------------------------------------------
// ntc_lexer
// Per-token state (float automaton, integer recognizer, accumulator) and the
// single-pass logic that steps it by one character and forms the result.
// ----------------------------------------------------------------------------
module ntc_lexer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  ntc_pkg::t_in_beat i_beat,
    output ntc_pkg::t_out_beat o_result
);

    logic [3:0]      r_fstate, n_fstate;
    logic            r_int_ok, n_int_ok;
    ntc_pkg::t_value r_acc,    n_acc;
    logic            r_neg,    n_neg;
    logic            r_first;
    logic            r_digit,  n_digit;

    logic            is_digit;
    logic            is_sign;
    logic [2:0]      cls;
    ntc_pkg::t_value value;

    always_comb begin
        is_digit = (i_beat.ch >= 8'h30) && (i_beat.ch <= 8'h39);
        is_sign  = (i_beat.ch == 8'h2b) || (i_beat.ch == 8'h2d);

        if (is_sign) begin
            cls = ntc_pkg::CLS_SIGN;
        end else if (is_digit) begin
            cls = ntc_pkg::CLS_DIGIT;
        end else if (i_beat.ch == 8'h65 || i_beat.ch == 8'h45) begin
            cls = ntc_pkg::CLS_EXP;
        end else if (i_beat.ch == 8'h2e) begin
            cls = ntc_pkg::CLS_DOT;
        end else begin
            cls = ntc_pkg::CLS_OTHER;
        end
        n_fstate = ntc_pkg::float_next(r_fstate, cls);

        n_int_ok = r_int_ok;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_digit  = r_digit;
        if (r_first && is_sign) begin
            n_neg = (i_beat.ch == 8'h2d);
        end else if (is_digit) begin
            // times ten as two shifted adds, digit is the low nibble
            n_acc   = (r_acc << 3) + (r_acc << 1) + ntc_pkg::t_value'(i_beat.ch[3:0]);
            n_digit = 1'b1;
        end else begin
            n_int_ok = 1'b0;
        end

        value = n_neg ? (ntc_pkg::t_value'(0) - n_acc) : n_acc;

        o_result.int_value = '0;
        if (n_int_ok && n_digit) begin
            o_result.kind      = ntc_pkg::KIND_INT;
            o_result.int_value = 32'($signed(value));
        end else if (n_fstate inside {4'd3, 4'd4, 4'd6, 4'd9}) begin
            o_result.kind = ntc_pkg::KIND_FLOAT;
        end else begin
            o_result.kind = ntc_pkg::KIND_SYMBOL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstate <= ntc_pkg::FS_START;
            r_int_ok <= 1'b1;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_first  <= 1'b1;
            r_digit  <= 1'b0;
        end else if (i_step) begin
            if (i_beat.last) begin
                // token done, start clean
                r_fstate <= ntc_pkg::FS_START;
                r_int_ok <= 1'b1;
                r_acc    <= '0;
                r_neg    <= 1'b0;
                r_first  <= 1'b1;
                r_digit  <= 1'b0;
            end else begin
                r_fstate <= n_fstate;
                r_int_ok <= n_int_ok;
                r_acc    <= n_acc;
                r_neg    <= n_neg;
                r_first  <= 1'b0;
                r_digit  <= n_digit;
            end
        end
    end

endmodule

/* hw/rtl/numeric_token_classifier.sv */
// A result passes the input register, then the result register, once the last
// character of a token is accepted.
// Throughput: one character per cycle, set by the lexer step.
// A full result register that is stalled holds back a last character only.
// Reset (i_rst_n low, synchronous) empties both registers and starts a new token.
// ----------------------------------------------------------------------------
// numeric_token_classifier
// Classes each token as integer, floating constant or symbol and reports the
// wrapped integer value.
// ----------------------------------------------------------------------------
module numeric_token_classifier (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ntc_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ntc_pkg::t_out_beat o_out_data
);

    logic               r_in_valid;
    ntc_pkg::t_in_beat  r_in;
    logic               r_out_valid;
    ntc_pkg::t_out_beat r_out;

    logic               out_free;
    logic               step;
    ntc_pkg::t_out_beat result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && (!r_in.last || out_free);
    assign o_in_stall = r_in_valid && !step;

    ntc_lexer u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_beat   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.last) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/ntc_checker.sv */
// ----------------------------------------------------------------------------
// ntc_checker
// Port-level checks on the numeric token classifier, bound to the top level.
// ----------------------------------------------------------------------------
module ntc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input ntc_pkg::t_in_beat  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ntc_pkg::t_out_beat o_out_data
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.kind == ntc_pkg::KIND_INT ||
                         o_out_data.kind == ntc_pkg::KIND_FLOAT ||
                         o_out_data.kind == ntc_pkg::KIND_SYMBOL))
        else $error("illegal result kind");

    // only integers carry a value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != ntc_pkg::KIND_INT
            |-> o_out_data.int_value == 32'sd0)
        else $error("non-integer result with a value");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind numeric_token_classifier ntc_checker u_ntc_checker (.*);
